[rtl/core/wlst_pkg.sv]
package wlst_pkg;

   // Request word: one lookup, update or erase request
   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] base_address;
      logic [7:0]  slot_count;
      logic [15:0] slot_size;
      logic [7:0]  slot_written;
   } req_type;

   // Response word
   typedef struct packed {
      logic [7:0] slot_index;
      logic [1:0] status;
   } rsp_type;

   // Stored metadata record, 64 bits
   typedef struct packed {
      logic [15:0] base;
      logic [7:0]  count;
      logic [7:0]  last;
      logic [15:0] size;
      logic [15:0] sum;
   } rec_type;

   // Active segment register layout
   typedef struct packed {
      logic [15:0] base;
      logic [7:0]  count;
      logic [15:0] size;
   } seg_type;

   // Request modes
   localparam logic [1:0] MODE_READ     = 2'd0;
   localparam logic [1:0] MODE_WRITE    = 2'd1;
   localparam logic [1:0] MODE_REMEMBER = 2'd2;
   localparam logic [1:0] MODE_ERASE    = 2'd3;

   // Response status codes
   localparam logic [1:0] STATUS_USED    = 2'd0;
   localparam logic [1:0] STATUS_DEFAULT = 2'd1;
   localparam logic [1:0] STATUS_NO_FREE = 2'd2;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 40;

   localparam logic [15:0] ERASED_BASE = 16'hFFFF;

   // Controller to datapath commands
   typedef struct packed {
      logic load;    // latch a new request, clear scan results
      logic rd_en;   // read record at scan address, advance address
      logic finish;  // form response, write back or erase
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic last_addr;  // scan address is on the final record
   } sts_type;

   // 16-bit additive checksum of a record
   function automatic logic [15:0] rec_checksum(input logic [15:0] base,
                                                input logic [7:0]  count,
                                                input logic [7:0]  last,
                                                input logic [15:0] size);
      rec_checksum = base + {8'd0, count} + {8'd0, last} + size;
   endfunction

   function automatic logic rec_is_valid(input rec_type r);
      rec_is_valid = (r.base != ERASED_BASE) && (r.count != 8'd0) && (r.last < r.count) &&
                     (r.size != 16'd0) &&
                     (r.sum == rec_checksum(r.base, r.count, r.last, r.size));
   endfunction

   // (last + 1) mod count, given last < count
   function automatic logic [7:0] next_slot(input logic [7:0] last,
                                            input logic [7:0] count);
      logic [8:0] inc;
      inc = {1'b0, last} + 9'd1;
      next_slot = (inc == {1'b0, count}) ? 8'd0 : inc[7:0];
   endfunction

endpackage

[rtl/core/wlst_ctrl.sv]
module wlst_ctrl
   import wlst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd,
   input  sts_type sts
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_WAIT   = 3'd2;
   localparam logic [2:0] S_FINISH = 3'd3;
   localparam logic [2:0] S_OUT    = 3'd4;

   logic [2:0] state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (sts.last_addr) state_in = S_WAIT;
         end
         S_WAIT:   state_in = S_FINISH;
         S_FINISH: state_in = S_OUT;
         S_OUT: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // Handshake and datapath commands
   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = (state_ff == S_OUT);
   assign cmd.load   = (state_ff == S_IDLE) && req_valid;
   assign cmd.rd_en  = (state_ff == S_SCAN);
   assign cmd.finish = (state_ff == S_FINISH);

endmodule

[rtl/core/wlst_dpath.sv]
module wlst_dpath
   import wlst_pkg::*;
#(
   parameter int RECORD_COUNT    = 16,
   parameter int ACTIVE_SEGMENTS = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  req_type                req_word,
   output rsp_type                rsp_word,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   input  cmd_type                cmd,
   output sts_type                sts
);

   localparam int IDX_W = (RECORD_COUNT > 1) ? $clog2(RECORD_COUNT) : 1;

   // Active segment registers
   seg_type seg_ff [ACTIVE_SEGMENTS];

   for (genvar g = 0; g < ACTIVE_SEGMENTS; g++) begin : g_seg
      always_ff @(posedge clock) begin
         if (reset) begin
            seg_ff[g] <= '0;
         end else if (csr_wr_en && (csr_index == CSR_INDEX_W'(g))) begin
            seg_ff[g] <= seg_type'(csr_wr_data);
         end
      end
   end

   // Latched request
   req_type req_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_word;
   end

   // Scan address
   logic [IDX_W-1:0] addr_ff;

   always_ff @(posedge clock) begin
      if (cmd.load)       addr_ff <= '0;
      else if (cmd.rd_en) addr_ff <= addr_ff + IDX_W'(1);
   end

   assign sts.last_addr = (addr_ff == IDX_W'(RECORD_COUNT - 1));

   // Record memory with registered read; written bits stand in for the erased state
   logic [63:0]       mem [RECORD_COUNT];
   logic [63:0]       rd_data_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic              rd_vld_ff;
   logic [RECORD_COUNT-1:0] written_ff;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_idx;
   rec_type           wr_rec;
   logic              erase_en;

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[addr_ff];
         rd_idx_ff  <= addr_ff;
      end
      if (wr_en) mem[wr_idx] <= wr_rec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         written_ff <= '0;
      end else begin
         rd_vld_ff <= cmd.rd_en;
         if (erase_en)   written_ff         <= '0;
         else if (wr_en) written_ff[wr_idx] <= 1'b1;
      end
   end

   // Classify the record just read
   rec_type rec;
   logic    rec_valid, same_bc, exact, active;

   always_comb begin
      rec       = written_ff[rd_idx_ff] ? rec_type'(rd_data_ff) : rec_type'('1);
      rec_valid = rec_is_valid(rec);
      same_bc   = rec_valid && (rec.base == req_ff.base_address) &&
                  (rec.count == req_ff.slot_count);
      exact     = same_bc && (rec.size == req_ff.slot_size);
      active    = 1'b0;
      for (int i = 0; i < ACTIVE_SEGMENTS; i++) begin
         if ((rec.base == seg_ff[i].base) && (rec.count == seg_ff[i].count) &&
             (rec.size == seg_ff[i].size)) begin
            active = 1'b1;
         end
      end
   end

   // First-hit trackers for each class of record
   logic             exact_hit_ff, compat_hit_ff, stale_hit_ff, empty_hit_ff;
   logic [IDX_W-1:0] exact_idx_ff, compat_idx_ff, stale_idx_ff, empty_idx_ff;
   logic [7:0]       exact_last_ff, compat_last_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         exact_hit_ff  <= 1'b0;
         compat_hit_ff <= 1'b0;
         stale_hit_ff  <= 1'b0;
         empty_hit_ff  <= 1'b0;
      end else if (rd_vld_ff) begin
         if (exact && !exact_hit_ff) begin
            exact_hit_ff  <= 1'b1;
            exact_idx_ff  <= rd_idx_ff;
            exact_last_ff <= rec.last;
         end
         if (same_bc && !exact && !compat_hit_ff) begin
            compat_hit_ff  <= 1'b1;
            compat_idx_ff  <= rd_idx_ff;
            compat_last_ff <= rec.last;
         end
         if (rec_valid && !active && !stale_hit_ff) begin
            stale_hit_ff <= 1'b1;
            stale_idx_ff <= rd_idx_ff;
         end
         if (!rec_valid && !empty_hit_ff) begin
            empty_hit_ff <= 1'b1;
            empty_idx_ff <= rd_idx_ff;
         end
      end
   end

   // Target record for remember: exact, compatible, stale, empty
   logic target_hit;

   always_comb begin
      target_hit = exact_hit_ff || compat_hit_ff || stale_hit_ff || empty_hit_ff;
      if (exact_hit_ff)       wr_idx = exact_idx_ff;
      else if (compat_hit_ff) wr_idx = compat_idx_ff;
      else if (stale_hit_ff)  wr_idx = stale_idx_ff;
      else                    wr_idx = empty_idx_ff;
      wr_rec.base  = req_ff.base_address;
      wr_rec.count = req_ff.slot_count;
      wr_rec.last  = req_ff.slot_written;
      wr_rec.size  = req_ff.slot_size;
      wr_rec.sum   = rec_checksum(req_ff.base_address, req_ff.slot_count,
                                  req_ff.slot_written, req_ff.slot_size);
      wr_en    = cmd.finish && (req_ff.mode == MODE_REMEMBER) && target_hit;
      erase_en = cmd.finish && (req_ff.mode == MODE_ERASE);
   end

   // Response
   rsp_type rsp_ff, rsp_in;

   always_comb begin
      rsp_in.slot_index = 8'd0;
      rsp_in.status     = STATUS_USED;
      case (req_ff.mode)
         MODE_READ: begin
            if (exact_hit_ff) begin
               rsp_in.slot_index = exact_last_ff;
            end else begin
               rsp_in.slot_index = req_ff.slot_count - 8'd1;
               rsp_in.status     = STATUS_DEFAULT;
            end
         end
         MODE_WRITE: begin
            if (exact_hit_ff) begin
               rsp_in.slot_index = next_slot(exact_last_ff, req_ff.slot_count);
            end else if (compat_hit_ff) begin
               rsp_in.slot_index = next_slot(compat_last_ff, req_ff.slot_count);
            end else begin
               rsp_in.status = STATUS_DEFAULT;
            end
         end
         MODE_REMEMBER: begin
            if (!target_hit) rsp_in.status = STATUS_NO_FREE;
         end
         default: begin
            rsp_in.status = STATUS_USED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) rsp_ff <= rsp_in;
   end

   assign rsp_word = rsp_ff;

endmodule

[rtl/core/wear_level_slot_tracker.sv]
// After an accepted request the sequencer scans the table, reading one record per
// cycle, waits for the last registered read, then commits and shows the response.
// A new request is taken only after the response word has been taken.
// Reset clears control state and active segments; the record table reads as
// erased (all ones) right after reset.
module wear_level_slot_tracker
   import wlst_pkg::*;
#(
   parameter int RECORD_COUNT    = 16,
   parameter int ACTIVE_SEGMENTS = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_word,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   // Sequencer
   wlst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Record table, scan and response
   wlst_dpath #(
      .RECORD_COUNT    (RECORD_COUNT),
      .ACTIVE_SEGMENTS (ACTIVE_SEGMENTS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_word    (req_word),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

[test/tb_wear_level_slot_tracker.sv]
`timescale 1ns / 100ps

module tb_wear_level_slot_tracker;
   import wlst_pkg::*;

   localparam int RECORD_COUNT     = 16;
   localparam int NUM_SEGMENT_REGS = 5;
   localparam int POOL_SIZE        = 20;
   localparam int PHASE_WORDS      = 175;
   localparam int DRAIN_LIMIT      = 2000;

   localparam logic [CSR_INDEX_W-1:0] REG_SEGMENT_0 = '0;

   // Directed segments: base, count, size
   localparam seg_type SEG_A          = {16'h1234, 8'd8,   16'h0200};
   localparam seg_type SEG_A_RESIZED  = {16'h1234, 8'd8,   16'h0400};
   localparam seg_type SEG_B          = {16'h0000, 8'd1,   16'h0001};
   localparam seg_type SEG_C          = {16'hFFFE, 8'd255, 16'hFFFF};
   localparam seg_type SEG_D          = {16'h5555, 8'd4,   16'h0004};
   localparam seg_type SEG_ZERO_COUNT = {16'h0042, 8'd0,   16'h0008};
   localparam seg_type SEG_ERASED     = {16'hFFFF, 8'd2,   16'h0010};
   localparam seg_type SEG_NO_SIZE    = {16'h00FF, 8'd2,   16'h0000};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_word = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_word;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;

   // Predictor state: record table and active segment registers
   rec_type rec_table [RECORD_COUNT];
   seg_type seg_reg [NUM_SEGMENT_REGS];

   // Stimulus support
   seg_type               seg_pool [POOL_SIZE];
   logic [CSR_DATA_W-1:0] seg_plan [NUM_SEGMENT_REGS];
   rsp_type               pending_answers [$];

   int gap_pct    = 0;
   int stall_pct  = 0;
   int stall_left = 0;
   int mismatches = 0;
   int words_sent = 0;
   int answers_checked = 0;
   int mode_count [4]   = '{0, 0, 0, 0};
   int status_count [4] = '{0, 0, 0, 0};

   wear_level_slot_tracker #(
      .RECORD_COUNT    (RECORD_COUNT),
      .ACTIVE_SEGMENTS (NUM_SEGMENT_REGS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [15:0] record_sum(input rec_type r);
      return r.base + 16'(r.count) + 16'(r.last) + r.size;
   endfunction

   function automatic bit record_ok(input rec_type r);
      return r.base != ERASED_BASE && r.count != 8'd0 && r.last < r.count &&
             r.size != 16'd0 && r.sum == record_sum(r);
   endfunction

   // Valid record that still belongs to one of the active segments
   function automatic bit record_live(input rec_type r);
      bit hit;
      hit = 1'b0;
      if (record_ok(r))
         for (int i = 0; i < NUM_SEGMENT_REGS; i++)
            if (r.base == seg_reg[i].base && r.count == seg_reg[i].count &&
                r.size == seg_reg[i].size)
               hit = 1'b1;
      return hit;
   endfunction

   // Record to update: exact, then same base and count, then stale, then empty
   function automatic int pick_record(input logic [15:0] base, input logic [7:0] count,
                                      input logic [15:0] size);
      int exact_at, compat_at, stale_at, empty_at;
      exact_at = -1;
      compat_at = -1;
      stale_at = -1;
      empty_at = -1;
      for (int i = 0; i < RECORD_COUNT; i++) begin
         if (record_ok(rec_table[i]) && rec_table[i].base == base &&
             rec_table[i].count == count) begin
            if (rec_table[i].size == size && exact_at < 0)
               exact_at = i;
            if (compat_at < 0)
               compat_at = i;
         end
         if (!record_ok(rec_table[i])) begin
            if (empty_at < 0)
               empty_at = i;
         end else if (!record_live(rec_table[i]) && stale_at < 0) begin
            stale_at = i;
         end
      end
      if (exact_at >= 0)
         return exact_at;
      if (compat_at >= 0)
         return compat_at;
      if (stale_at >= 0)
         return stale_at;
      return empty_at;
   endfunction

   // Expected answer for one request word; updates the record table
   function automatic rsp_type predict_slot_answer(input req_type w);
      rsp_type answer;
      rec_type r;
      int      pick;
      answer.slot_index = 8'd0;
      answer.status = STATUS_USED;
      case (w.mode)
         MODE_READ: begin
            answer.slot_index = w.slot_count - 8'd1;
            answer.status = STATUS_DEFAULT;
            // scan downward so the lowest matching record wins
            for (int i = RECORD_COUNT - 1; i >= 0; i--) begin
               r = rec_table[i];
               if (record_ok(r) && r.base == w.base_address && r.count == w.slot_count &&
                   r.size == w.slot_size) begin
                  answer.slot_index = r.last;
                  answer.status = STATUS_USED;
               end
            end
         end
         MODE_WRITE: begin
            answer.status = STATUS_DEFAULT;
            pick = pick_record(w.base_address, w.slot_count, w.slot_size);
            if (pick >= 0) begin
               r = rec_table[pick];
               // a foreign record's slot is never handed out
               if (record_ok(r) && r.base == w.base_address && r.count == w.slot_count &&
                   w.slot_count != 8'd0) begin
                  answer.slot_index = 8'((int'(r.last) + 1) % int'(w.slot_count));
                  answer.status = STATUS_USED;
               end
            end
         end
         MODE_REMEMBER: begin
            pick = pick_record(w.base_address, w.slot_count, w.slot_size);
            if (pick < 0) begin
               answer.status = STATUS_NO_FREE;
            end else begin
               r.base  = w.base_address;
               r.count = w.slot_count;
               r.last  = w.slot_written;
               r.size  = w.slot_size;
               r.sum   = record_sum(r);
               rec_table[pick] = r;
            end
         end
         default: begin
            for (int i = 0; i < RECORD_COUNT; i++)
               rec_table[i] = '1;
         end
      endcase
      return answer;
   endfunction

   // ---------------------------------------------------------------- driving

   // Send one request word and queue its expected answer
   task automatic send_word(input req_type w);
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pending_answers.push_back(predict_slot_answer(w));
      words_sent++;
      mode_count[w.mode]++;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6))
            @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      if (index < NUM_SEGMENT_REGS)
         seg_reg[index] = value;
   endtask

   task automatic program_segments();
      for (int i = 0; i < NUM_SEGMENT_REGS; i++)
         write_csr(REG_SEGMENT_0 + CSR_INDEX_W'(i), seg_plan[i]);
   endtask

   // Wait until every answer is back and the block has gone quiet
   task automatic settle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (pending_answers.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (RECORD_COUNT + 4) @(posedge clock);
   endtask

   function automatic req_type seg_word(input logic [1:0] mode, input seg_type s,
                                        input logic [7:0] slot);
      req_type w;
      w.mode         = mode;
      w.base_address = s.base;
      w.slot_count   = s.count;
      w.slot_size    = s.size;
      w.slot_written = slot;
      return w;
   endfunction

   function automatic req_type random_word();
      seg_type     s;
      int          roll;
      logic [1:0]  mode;
      logic [7:0]  slot;
      roll = $urandom_range(0, 99);
      if (roll < 2)
         mode = MODE_ERASE;
      else if (roll < 33)
         mode = MODE_READ;
      else if (roll < 65)
         mode = MODE_WRITE;
      else
         mode = MODE_REMEMBER;
      if ($urandom_range(0, 99) < 85) begin
         s = seg_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else begin
         // noise: any segment, now and then a degenerate one
         s.base  = 16'($urandom);
         s.count = 8'($urandom);
         s.size  = 16'($urandom);
         case ($urandom_range(0, 7))
            0: s.base = ERASED_BASE;
            1: s.count = 8'd0;
            2: s.size = 16'd0;
            default: ;
         endcase
      end
      if (s.count != 8'd0 && $urandom_range(0, 9) != 0)
         slot = 8'($urandom_range(0, int'(s.count) - 1));
      else
         slot = 8'($urandom);
      return seg_word(mode, s, slot);
   endfunction

   // Segments that recur; every fourth shares base and count with its neighbor
   task automatic build_pool();
      for (int i = 0; i < POOL_SIZE; i++) begin
         if (i % 4 == 3) begin
            seg_pool[i] = seg_pool[i - 1];
            seg_pool[i].size = 16'($urandom_range(1, 16'hFFFF));
         end else begin
            seg_pool[i].base  = 16'($urandom_range(0, 16'hFFFE));
            seg_pool[i].count = (i % 3 == 0) ? 8'($urandom_range(1, 4)) :
                                               8'($urandom_range(1, 255));
            seg_pool[i].size  = 16'($urandom_range(1, 16'hFFFF));
         end
      end
   endtask

   // ---------------------------------------------------------------- checking

   // Receiver stalls in random bursts
   always @(posedge clock) begin
      if (reset || stall_pct == 0) begin
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 5);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            $error("response word with no request outstanding: slot_index %0d status %0d",
                   rsp_word.slot_index, rsp_word.status);
            mismatches++;
         end else begin
            want = pending_answers.pop_front();
            answers_checked++;
            status_count[rsp_word.status]++;
            if (rsp_word.slot_index !== want.slot_index) begin
               $error("slot_index: expected %0d, got %0d", want.slot_index,
                      rsp_word.slot_index);
               mismatches++;
            end
            if (rsp_word.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_word.status);
               mismatches++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // Lookup, update, wrap, stale takeover and degenerate segments
   task automatic test_directed_cases();
      gap_pct   = 30;
      stall_pct = 30;
      seg_plan[0] = SEG_A;
      seg_plan[1] = SEG_C;
      seg_plan[2] = '0;
      seg_plan[3] = '0;
      seg_plan[4] = '0;
      program_segments();
      send_word(seg_word(MODE_READ, SEG_A, 8'd0));           // empty table: default
      send_word(seg_word(MODE_WRITE, SEG_A, 8'd0));
      send_word(seg_word(MODE_REMEMBER, SEG_A, 8'd7));
      send_word(seg_word(MODE_READ, SEG_A, 8'd0));
      send_word(seg_word(MODE_WRITE, SEG_A, 8'd0));          // last slot wraps to 0
      send_word(seg_word(MODE_REMEMBER, SEG_A, 8'd3));
      send_word(seg_word(MODE_WRITE, SEG_A, 8'd0));
      send_word(seg_word(MODE_READ, SEG_A_RESIZED, 8'd0));   // size differs: no exact hit
      send_word(seg_word(MODE_WRITE, SEG_A_RESIZED, 8'd0));  // same base and count
      send_word(seg_word(MODE_REMEMBER, SEG_A_RESIZED, 8'd5));
      send_word(seg_word(MODE_READ, SEG_A, 8'd0));
      send_word(seg_word(MODE_REMEMBER, SEG_B, 8'd0));       // inactive segment
      send_word(seg_word(MODE_WRITE, SEG_B, 8'd0));
      send_word(seg_word(MODE_REMEMBER, SEG_C, 8'd254));     // takes a stale record
      send_word(seg_word(MODE_READ, SEG_C, 8'd0));
      send_word(seg_word(MODE_WRITE, SEG_C, 8'd0));
      send_word(seg_word(MODE_WRITE, SEG_D, 8'd0));          // foreign record only
      send_word(seg_word(MODE_REMEMBER, SEG_A, 8'd8));       // slot beyond count
      send_word(seg_word(MODE_READ, SEG_A, 8'd0));
      send_word(seg_word(MODE_READ, SEG_ZERO_COUNT, 8'd0));  // count - 1 wraps
      send_word(seg_word(MODE_WRITE, SEG_ZERO_COUNT, 8'd0));
      send_word(seg_word(MODE_REMEMBER, SEG_ERASED, 8'd1));
      send_word(seg_word(MODE_REMEMBER, SEG_NO_SIZE, 8'd1));
      send_word(seg_word(MODE_ERASE, SEG_C, 8'hFF));
      send_word(seg_word(MODE_READ, SEG_C, 8'd0));
      settle();
   endtask

   // All-ones and all-zero registers, plus writes to unused indexes
   task automatic test_register_extremes();
      for (int i = 0; i < NUM_SEGMENT_REGS; i++)
         seg_plan[i] = '1;
      program_segments();
      repeat (8) send_word(random_word());
      settle();
      for (int i = NUM_SEGMENT_REGS; i < (1 << CSR_INDEX_W); i++)
         write_csr(REG_SEGMENT_0 + CSR_INDEX_W'(i), seg_pool[i]);
      repeat (8) send_word(random_word());
      settle();
      for (int i = 0; i < NUM_SEGMENT_REGS; i++)
         seg_plan[i] = '0;
      program_segments();
      repeat (8) send_word(random_word());
      settle();
   endtask

   // Mostly recurring segments so records fill, age and get taken over
   task automatic test_random_traffic();
      logic [63:0] noise;
      for (int phase = 0; phase < 4; phase++) begin
         for (int i = 0; i < NUM_SEGMENT_REGS; i++) begin
            noise = {$urandom, $urandom};
            if (phase == 1 && i < 3)
               seg_plan[i] = noise[CSR_DATA_W-1:0];
            else
               seg_plan[i] = seg_pool[$urandom_range(0, POOL_SIZE - 1)];
         end
         program_segments();
         case (phase)
            0: begin gap_pct = 25; stall_pct = 25; end
            1: begin gap_pct = 50; stall_pct = 50; end
            2: begin gap_pct = 0;  stall_pct = 30; end
            default: begin gap_pct = 0; stall_pct = 0; end
         endcase
         repeat (PHASE_WORDS) send_word(random_word());
         settle();
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      for (int i = 0; i < RECORD_COUNT; i++)
         rec_table[i] = '1;
      for (int i = 0; i < NUM_SEGMENT_REGS; i++)
         seg_reg[i] = '0;
      build_pool();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_register_extremes();
      test_random_traffic();

      if (pending_answers.size() != 0) begin
         $error("%0d expected responses never arrived", pending_answers.size());
         mismatches++;
      end
      $display("Sent %0d words: %0d read, %0d write, %0d remember, %0d erase",
               words_sent, mode_count[MODE_READ], mode_count[MODE_WRITE],
               mode_count[MODE_REMEMBER], mode_count[MODE_ERASE]);
      $display("Checked %0d responses: %0d used, %0d default, %0d no free",
               answers_checked, status_count[STATUS_USED], status_count[STATUS_DEFAULT],
               status_count[STATUS_NO_FREE]);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

[files.f]
rtl/core/wlst_pkg.sv
rtl/core/wlst_ctrl.sv
rtl/core/wlst_dpath.sv
rtl/core/wear_level_slot_tracker.sv
test/tb_wear_level_slot_tracker.sv
